// ===== rtl/mtr_pkg.sv =====
// Shared types, character constants and match helpers for the markup token replacer.
// Depends on nothing; every other file but mtr_checker imports it.
`default_nettype none

package mtr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MAX_RES = 6;   // most results one input byte can cause
  localparam int unsigned HOLD_N  = 5;   // deepest partial match held back
  localparam int unsigned CNT_W   = 3;   // holds 0..MAX_RES

  localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_LT   = 8'h3C;  // '<'
  localparam logic [BYTE_W-1:0] CH_GT   = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;  // '&'
  localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;  // ';'
  localparam logic [BYTE_W-1:0] CH_LB   = 8'h62;  // 'b'
  localparam logic [BYTE_W-1:0] CH_UB   = 8'h42;  // 'B'
  localparam logic [BYTE_W-1:0] CH_LR   = 8'h72;  // 'r'
  localparam logic [BYTE_W-1:0] CH_UR   = 8'h52;  // 'R'
  localparam logic [BYTE_W-1:0] CH_LE   = 8'h65;  // 'e'
  localparam logic [BYTE_W-1:0] CH_LM   = 8'h6D;  // 'm'
  localparam logic [BYTE_W-1:0] CH_LS   = 8'h73;  // 's'
  localparam logic [BYTE_W-1:0] CH_LP   = 8'h70;  // 'p'

  // Token currently being matched
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BR   = 2'd1,
    KIND_EMSP = 2'd2
  } kind_t;

  // One queued burst: the result bytes of one input byte, in order
  typedef struct packed {
    logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]               cnt;
  } burst_t;

  // Does c continue "<br>" at position pos (case-insensitive b and r)?
  function automatic logic br_expect(input logic [CNT_W-1:0] pos,
                                     input logic [BYTE_W-1:0] c);
    logic ok;
    ok = 1'b0;
    unique case (pos)
      3'd1:    ok = (c == CH_LB) || (c == CH_UB);
      3'd2:    ok = (c == CH_LR) || (c == CH_UR);
      3'd3:    ok = (c == CH_GT);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Does c continue "&emsp;" at position pos?
  function automatic logic emsp_expect(input logic [CNT_W-1:0] pos,
                                       input logic [BYTE_W-1:0] c);
    logic ok;
    ok = 1'b0;
    unique case (pos)
      3'd1:    ok = (c == CH_LE);
      3'd2:    ok = (c == CH_LM);
      3'd3:    ok = (c == CH_LS);
      3'd4:    ok = (c == CH_LP);
      3'd5:    ok = (c == CH_SEMI);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/markup_token_replacer.sv =====
// Markup token replacer: a byte's first result passes a queue entry, then the output
// register. One input byte per cycle while each byte yields at most one result and
// the output is not stalled; a byte with k results loads the output register k times,
// the burst queue (QUEUE_DEPTH entries) absorbing the difference. Bytes held in a partial
// match give no result. Synchronous active-low reset: prefix pending, no match, empty queue.
`default_nettype none

module markup_token_replacer import mtr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast   // last_of_run
);

  burst_t push_data, head;
  logic   push, q_full, pop, q_nonempty;

  mtr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  mtr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .nonempty  (q_nonempty)
  );

  mtr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (q_nonempty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/mtr_front.sv =====
// Front end: accepts text bytes, tracks message start and partial token matches,
// and turns each byte into a burst of result bytes for the queue. Uses mtr_pkg.
`default_nettype none

module mtr_front import mtr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              q_full,
  output logic                   push,
  output burst_t                 push_data
);

  logic                          ams_r, ams_nxt;     // prefix pending
  kind_t                         kind_r, kind_nxt;
  logic [CNT_W-1:0]              hc_r, hc_nxt;
  logic [HOLD_N-1:0][BYTE_W-1:0] held_r, held_nxt;

  logic [HOLD_N-1:0][BYTE_W-1:0] pre;
  logic [CNT_W-1:0]              npre;
  logic                          tail;
  kind_t                         fkind;
  logic [CNT_W-1:0]              fhc;
  logic                          match;
  logic                          accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Classify the byte: leading bytes (prefix, flushed or replacement) plus optional tail
  always_comb begin
    ams_nxt  = ams_r;
    kind_nxt = kind_r;
    hc_nxt   = hc_r;
    held_nxt = held_r;
    pre      = held_r;
    npre     = '0;
    tail     = 1'b0;
    fkind    = kind_r;
    fhc      = hc_r;
    match    = 1'b0;
    if (in_byte == CH_NUL) begin
      // terminator: emit prefix of an empty message or flush what is held
      if (ams_r) begin
        pre[0] = CH_NL;
        pre[1] = CH_TAB;
        npre   = 3'd2;
      end else begin
        npre = hc_r;
      end
      hc_nxt   = '0;
      kind_nxt = KIND_NONE;
      ams_nxt  = 1'b1;
    end else begin
      if (ams_r) begin
        pre[0]  = CH_NL;
        pre[1]  = CH_TAB;
        npre    = 3'd2;
        fkind   = KIND_NONE;
        fhc     = '0;
        ams_nxt = 1'b0;
      end
      unique case (fkind)
        KIND_BR:   match = br_expect(fhc, in_byte);
        KIND_EMSP: match = emsp_expect(fhc, in_byte);
        default:   match = 1'b0;
      endcase
      if (match) begin
        if (fkind == KIND_BR && fhc == 3'd3) begin
          pre[0]   = CH_NL;
          pre[1]   = CH_TAB;
          npre     = 3'd2;
          hc_nxt   = '0;
          kind_nxt = KIND_NONE;
        end else if (fkind == KIND_EMSP && fhc == 3'd5) begin
          pre[0]   = CH_TAB;
          npre     = 3'd1;
          hc_nxt   = '0;
          kind_nxt = KIND_NONE;
        end else begin
          held_nxt[fhc] = in_byte;
          hc_nxt        = fhc + 3'd1;
        end
      end else begin
        // failed match: flush held bytes, then look at this byte afresh
        if (fkind == KIND_BR || fkind == KIND_EMSP) begin
          npre = fhc;
        end
        if (in_byte == CH_LT) begin
          kind_nxt    = KIND_BR;
          held_nxt[0] = in_byte;
          hc_nxt      = 3'd1;
        end else if (in_byte == CH_AMP) begin
          kind_nxt    = KIND_EMSP;
          held_nxt[0] = in_byte;
          hc_nxt      = 3'd1;
        end else begin
          kind_nxt = KIND_NONE;
          hc_nxt   = '0;
          tail     = 1'b1;
        end
      end
    end
  end

  // Pack the burst: leading bytes first, the input byte fills the rest
  always_comb begin
    for (int i = 0; i < HOLD_N; i++) begin
      push_data.bytes[i] = (CNT_W'(i) < npre) ? pre[i] : in_byte;
    end
    push_data.bytes[MAX_RES-1] = in_byte;
    push_data.cnt = npre + CNT_W'(tail);
  end

  assign push = accept && (push_data.cnt != '0);

  // Advance match state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ams_r  <= 1'b1;
      kind_r <= KIND_NONE;
      hc_r   <= '0;
    end else if (accept) begin
      ams_r  <= ams_nxt;
      kind_r <= kind_nxt;
      hc_r   <= hc_nxt;
    end
  end

  // Held bytes are only read below the held count
  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mtr_queue.sv =====
// Short burst queue between the front and back ends of the token replacer.
// Register-based FIFO of burst_t entries; uses mtr_pkg.
`default_nettype none

module mtr_queue import mtr_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire burst_t push_data,
  output logic        full,
  input  wire logic   pop,
  output burst_t      head,
  output logic        nonempty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  burst_t           mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = mem_r[rptr_r];

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // Advance pointers with wrap at depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + AW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + AW'(1);
      end
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mtr_back.sv =====
// Back end: walks each queued burst into the output register, one result byte per cycle
// while the output is not stalled. Uses mtr_pkg.
`default_nettype none

module mtr_back import mtr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire burst_t            head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_last
);

  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              vld_r, vld_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;
  logic              load, at_end;

  assign load   = head_valid && (!vld_r || out_tready);
  assign at_end = (idx_r == head.cnt - CNT_W'(1));
  assign pop    = load && at_end;

  // Step through the burst; wrap to its start when the last byte loads
  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = at_end ? '0 : idx_r + CNT_W'(1);
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.bytes[idx_r];
      last_r <= at_end;
    end
  end

  assign out_tvalid = vld_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

// ===== rtl/mtr_checker.sv =====
// Port-level checks for the markup token replacer, bound to the top level.
// Sees only the top-level ports.
`default_nettype none

module mtr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Terminators never reach the output
  a_no_nul: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 8'h00)
    else $error("zero byte emitted");

  // An offered text byte carries known bits
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid |-> !$isunknown(in_tdata))
    else $error("offered text byte has unknown bits");

  // Reset leaves no result pending
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Reset leaves the input side ready
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind markup_token_replacer mtr_checker u_mtr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
